// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the quaternion conversion pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RMQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmq assertion failed");

// next-cycle implication
`define RMQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmq assertion failed");

`endif

// ===== hdl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Widths, codes and sideband types of the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

   localparam int FRAC_BITS  = 14;
   localparam int ONE        = 1 << FRAC_BITS;
   localparam int MAT_W      = 16;
   localparam int COMP_W     = 16;
   localparam int MAG_W      = 15;           // holds ONE
   localparam int NUM_W      = 18;           // signed sum of two entries
   localparam int T_W        = 17;           // clamped trace
   localparam int RAD_W      = 31;           // radicand and root register
   localparam int ROOT_W     = 16;
   localparam int SQRT_STEPS = 16;
   localparam int NUMER_W    = 31;           // divider dividend
   localparam int DIV_D_W    = 17;           // divider divisor
   localparam int QUO_W      = 17;
   localparam int DIV_STEPS  = QUO_W;
   localparam int SQ_W       = 29;
   localparam int LEN2_W     = 31;
   localparam int THR_W      = 29;
   localparam int THR_RESET  = 161061;
   localparam int LANES      = 4;
   localparam int BR_W       = 2;

   // dominant component codes
   localparam logic [BR_W-1:0] BR_X = 2'd0;
   localparam logic [BR_W-1:0] BR_Y = 2'd1;
   localparam logic [BR_W-1:0] BR_Z = 2'd2;
   localparam logic [BR_W-1:0] BR_W_CODE = 2'd3;

   // component lanes
   localparam int LANE_W = 0;
   localparam int LANE_X = 1;
   localparam int LANE_Y = 2;
   localparam int LANE_Z = 3;

   typedef struct packed {
      logic [BR_W-1:0]               branch;
      logic                          t_one;
      logic                          neg;
      logic [LANES-1:0][NUM_W-1:0]   num;
   } sq1_side_type;

   typedef struct packed {
      logic [BR_W-1:0]   branch;
      logic              t_one;
      logic              neg;
      logic              r_zero;
      logic [ROOT_W-1:0] dom;
      logic [LANES-1:0]  sgn;
      logic [LANES-1:0]  ovf;
   } div1_side_type;

   typedef struct packed {
      logic [LANES-1:0][COMP_W-1:0] c;
      logic [BR_W-1:0]              branch;
      logic                         renorm;
   } sq2_side_type;

   typedef struct packed {
      logic [LANES-1:0][COMP_W-1:0] c;
      logic [BR_W-1:0]              branch;
      logic                         renorm;
      logic                         len_zero;
      logic [LANES-1:0]             sgn;
      logic [LANES-1:0]             ovf;
   } div2_side_type;

endpackage

`default_nettype wire

// ===== hdl/rmq_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One digit step of the integer square root, registered, with a sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt_cell #(
   parameter int STEP = 0,
   parameter int PW   = 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire logic [rmq_pkg::RAD_W-1:0]  in_v,
   input  wire logic [rmq_pkg::RAD_W-1:0]  in_r,
   input  wire logic [PW-1:0]              in_side,
   output logic                            out_valid,
   output logic [rmq_pkg::RAD_W-1:0]       out_v,
   output logic [rmq_pkg::RAD_W-1:0]       out_r,
   output logic [PW-1:0]                   out_side
);

   localparam logic [rmq_pkg::RAD_W:0] BITV = (rmq_pkg::RAD_W+1)'(1) << (2 * STEP);

   logic                        valid_ff;
   logic [rmq_pkg::RAD_W-1:0]   v_ff, v_in, r_ff, r_in;
   logic [PW-1:0]               side_ff;
   logic [rmq_pkg::RAD_W:0]     trial;
   logic                        fits;

   // try subtracting root plus this digit
   always_comb begin
      trial = {1'b0, in_r} + BITV;
      fits  = {1'b0, in_v} >= trial;
      if (fits) begin
         v_in = in_v - trial[rmq_pkg::RAD_W-1:0];
         r_in = (in_r >> 1) + BITV[rmq_pkg::RAD_W-1:0];
      end else begin
         v_in = in_v;
         r_in = in_r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff    <= v_in;
         r_ff    <= r_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_v     = v_ff;
   assign out_r     = r_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ===== hdl/rmq_div_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_div_cell
// One quotient bit of a four-lane restoring divider, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div_cell #(
   parameter int J  = 0,
   parameter int PW = 1
) (
   input  wire logic                                                clock,
   input  wire logic                                                reset,
   input  wire logic                                                en,
   input  wire logic                                                in_valid,
   input  wire logic [rmq_pkg::LANES-1:0][rmq_pkg::NUMER_W-1:0]     in_rem,
   input  wire logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0]       in_q,
   input  wire logic [rmq_pkg::DIV_D_W-1:0]                         in_d,
   input  wire logic [PW-1:0]                                       in_side,
   output logic                                                     out_valid,
   output logic [rmq_pkg::LANES-1:0][rmq_pkg::NUMER_W-1:0]          out_rem,
   output logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0]            out_q,
   output logic [rmq_pkg::DIV_D_W-1:0]                              out_d,
   output logic [PW-1:0]                                            out_side
);

   localparam int WW = rmq_pkg::DIV_D_W + rmq_pkg::DIV_STEPS;

   logic                                                valid_ff;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::NUMER_W-1:0]     rem_ff, rem_in;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0]       q_ff, q_in;
   logic [rmq_pkg::DIV_D_W-1:0]                         d_ff;
   logic [PW-1:0]                                       side_ff;
   logic [WW-1:0]                                       dsh;

   // compare each lane against the shifted divisor
   always_comb begin
      dsh = WW'(in_d) << J;
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
         if (WW'(in_rem[i]) >= dsh) begin
            rem_in[i] = in_rem[i] - dsh[rmq_pkg::NUMER_W-1:0];
            q_in[i]   = in_q[i] | (rmq_pkg::QUO_W'(1) << J);
         end else begin
            rem_in[i] = in_rem[i];
            q_in[i]   = in_q[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         d_ff    <= in_d;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_q     = q_ff;
   assign out_d     = d_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ===== hdl/rotation_matrix_to_quat_unit.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quat_unit
// Q1.14 rotation matrix to unit quaternion, largest-diagonal method.
// ----------------------------------------------------------------------------
// A new request is taken every cycle while req_stall is low. The pipeline
// has 74 register stages: a 16-cell square root and a 17-cell four-lane
// divider for the components, then again a 16-cell root and a 17-cell
// divider for the length correction, plus eight single stages (front, two
// divider setups, component select, squares, length sum, threshold compare
// and the output register), after which the result is on the rsp_ ports.
// While a result waits on rsp_stall the whole pipeline holds and req_stall
// is raised. The renormalization threshold is written through csr_wr_en /
// csr_wr_data; the user must write it only while no request is in flight,
// as the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module rotation_matrix_to_quat_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [rmq_pkg::MAT_W-1:0]    req_m00,
   input  wire logic signed [rmq_pkg::MAT_W-1:0]    req_m01,
   input  wire logic signed [rmq_pkg::MAT_W-1:0]    req_m02,
   input  wire logic signed [rmq_pkg::MAT_W-1:0]    req_m10,
   input  wire logic signed [rmq_pkg::MAT_W-1:0]    req_m11,
   input  wire logic signed [rmq_pkg::MAT_W-1:0]    req_m12,
   input  wire logic signed [rmq_pkg::MAT_W-1:0]    req_m20,
   input  wire logic signed [rmq_pkg::MAT_W-1:0]    req_m21,
   input  wire logic signed [rmq_pkg::MAT_W-1:0]    req_m22,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [rmq_pkg::COMP_W-1:0]        rsp_quat_w,
   output logic signed [rmq_pkg::COMP_W-1:0]        rsp_quat_x,
   output logic signed [rmq_pkg::COMP_W-1:0]        rsp_quat_y,
   output logic signed [rmq_pkg::COMP_W-1:0]        rsp_quat_z,
   output logic [rmq_pkg::BR_W-1:0]                 rsp_branch_taken,
   output logic                                     rsp_was_renormalized,
   input  wire logic                                csr_wr_en,
   input  wire logic [rmq_pkg::THR_W-1:0]           csr_wr_data
);

   localparam int SQ1_PW  = $bits(rmq_pkg::sq1_side_type);
   localparam int DIV1_PW = $bits(rmq_pkg::div1_side_type);
   localparam int SQ2_PW  = $bits(rmq_pkg::sq2_side_type);
   localparam int DIV2_PW = $bits(rmq_pkg::div2_side_type);
   localparam int EW      = 20;
   localparam int DW      = rmq_pkg::DIV_D_W + rmq_pkg::DIV_STEPS;
   localparam logic [rmq_pkg::QUO_W-1:0]  ONE_Q   = rmq_pkg::QUO_W'(rmq_pkg::ONE);
   localparam logic [rmq_pkg::MAG_W-1:0]  ONE_M   = rmq_pkg::MAG_W'(rmq_pkg::ONE);
   localparam logic [rmq_pkg::LEN2_W-1:0] ONE_SQ  =
      rmq_pkg::LEN2_W'(1) << (2 * rmq_pkg::FRAC_BITS);
   localparam logic signed [rmq_pkg::COMP_W-1:0] ONE_C = rmq_pkg::COMP_W'(rmq_pkg::ONE);

   // global advance: hold everything while the result is refused
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // threshold register
   logic [rmq_pkg::THR_W-1:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= rmq_pkg::THR_W'(rmq_pkg::THR_RESET);
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // ---------------- front: branch, trace, numerators ----------------
   logic signed [EW-1:0]              e00, e01, e02, e10, e11, e12, e20, e21, e22, tt;
   logic signed [rmq_pkg::NUM_W-1:0]  fr_num [rmq_pkg::LANES];
   logic [rmq_pkg::T_W-1:0]           fr_t;
   rmq_pkg::sq1_side_type             fr_side;
   logic                              fr_valid_ff;
   logic [rmq_pkg::RAD_W-1:0]         fr_rad_ff;
   rmq_pkg::sq1_side_type             fr_side_ff;

   always_comb begin
      e00 = EW'(req_m00); e01 = EW'(req_m01); e02 = EW'(req_m02);
      e10 = EW'(req_m10); e11 = EW'(req_m11); e12 = EW'(req_m12);
      e20 = EW'(req_m20); e21 = EW'(req_m21); e22 = EW'(req_m22);
      for (int i = 0; i < rmq_pkg::LANES; i++) fr_num[i] = '0;
      fr_side.neg = 1'b0;
      if (e22 < 0) begin
         if (e00 > e11) begin
            fr_side.branch = rmq_pkg::BR_X;
            tt = EW'(rmq_pkg::ONE) + e00 - e11 - e22;
            fr_side.neg = e12 < e21;
            fr_num[rmq_pkg::LANE_W] = rmq_pkg::NUM_W'(e12 - e21);
            fr_num[rmq_pkg::LANE_Y] = rmq_pkg::NUM_W'(e01 + e10);
            fr_num[rmq_pkg::LANE_Z] = rmq_pkg::NUM_W'(e20 + e02);
         end else begin
            fr_side.branch = rmq_pkg::BR_Y;
            tt = EW'(rmq_pkg::ONE) - e00 + e11 - e22;
            fr_side.neg = e20 < e02;
            fr_num[rmq_pkg::LANE_W] = rmq_pkg::NUM_W'(e20 - e02);
            fr_num[rmq_pkg::LANE_X] = rmq_pkg::NUM_W'(e01 + e10);
            fr_num[rmq_pkg::LANE_Z] = rmq_pkg::NUM_W'(e12 + e21);
         end
      end else begin
         if (e00 < -e11) begin
            fr_side.branch = rmq_pkg::BR_Z;
            tt = EW'(rmq_pkg::ONE) - e00 - e11 + e22;
            fr_side.neg = e01 < e10;
            fr_num[rmq_pkg::LANE_W] = rmq_pkg::NUM_W'(e01 - e10);
            fr_num[rmq_pkg::LANE_X] = rmq_pkg::NUM_W'(e20 + e02);
            fr_num[rmq_pkg::LANE_Y] = rmq_pkg::NUM_W'(e12 + e21);
         end else begin
            fr_side.branch = rmq_pkg::BR_W_CODE;
            tt = EW'(rmq_pkg::ONE) + e00 + e11 + e22;
            fr_num[rmq_pkg::LANE_X] = rmq_pkg::NUM_W'(e12 - e21);
            fr_num[rmq_pkg::LANE_Y] = rmq_pkg::NUM_W'(e20 - e02);
            fr_num[rmq_pkg::LANE_Z] = rmq_pkg::NUM_W'(e01 - e10);
         end
      end
      fr_t = (tt < 0) ? '0 : tt[rmq_pkg::T_W-1:0];
      fr_side.t_one = fr_t == rmq_pkg::T_W'(rmq_pkg::ONE);
      for (int i = 0; i < rmq_pkg::LANES; i++) fr_side.num[i] = fr_num[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else if (en) begin
         fr_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fr_rad_ff  <= rmq_pkg::RAD_W'(fr_t) << rmq_pkg::FRAC_BITS;
         fr_side_ff <= fr_side;
      end
   end

   // ---------------- root of the trace ----------------
   logic                        s1_valid [rmq_pkg::SQRT_STEPS+1];
   logic [rmq_pkg::RAD_W-1:0]   s1_v     [rmq_pkg::SQRT_STEPS+1];
   logic [rmq_pkg::RAD_W-1:0]   s1_r     [rmq_pkg::SQRT_STEPS+1];
   logic [SQ1_PW-1:0]           s1_side  [rmq_pkg::SQRT_STEPS+1];

   assign s1_valid[0] = fr_valid_ff;
   assign s1_v[0]     = fr_rad_ff;
   assign s1_r[0]     = '0;
   assign s1_side[0]  = fr_side_ff;

   for (genvar g = 0; g < rmq_pkg::SQRT_STEPS; g++) begin : g_sq1
      rmq_sqrt_cell #(.STEP(rmq_pkg::SQRT_STEPS-1-g), .PW(SQ1_PW)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(s1_valid[g]), .in_v(s1_v[g]), .in_r(s1_r[g]), .in_side(s1_side[g]),
         .out_valid(s1_valid[g+1]), .out_v(s1_v[g+1]), .out_r(s1_r[g+1]),
         .out_side(s1_side[g+1])
      );
   end

   // ---------------- divider 1 setup ----------------
   rmq_pkg::sq1_side_type                              p1_in;
   logic [rmq_pkg::ROOT_W-1:0]                         p1_r;
   logic [rmq_pkg::DIV_D_W-1:0]                        p1_d;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::NUMER_W-1:0]    p1_numer;
   logic signed [rmq_pkg::NUM_W-1:0]                   p1_n;
   logic [rmq_pkg::QUO_W-1:0]                          p1_mag;
   rmq_pkg::div1_side_type                             p1_side;
   logic                                               p1_valid_ff;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::NUMER_W-1:0]    p1_numer_ff;
   logic [rmq_pkg::DIV_D_W-1:0]                        p1_d_ff;
   rmq_pkg::div1_side_type                             p1_side_ff;

   always_comb begin
      p1_in  = rmq_pkg::sq1_side_type'(s1_side[rmq_pkg::SQRT_STEPS]);
      p1_r   = s1_r[rmq_pkg::SQRT_STEPS][rmq_pkg::ROOT_W-1:0];
      p1_d   = {p1_r, 1'b0};
      p1_side.branch = p1_in.branch;
      p1_side.t_one  = p1_in.t_one;
      p1_side.neg    = p1_in.neg;
      p1_side.r_zero = p1_r == '0;
      p1_side.dom    = rmq_pkg::ROOT_W'(({1'b0, p1_r} + (rmq_pkg::ROOT_W+1)'(1)) >> 1);
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
         p1_n   = $signed(p1_in.num[i]);
         p1_mag = rmq_pkg::QUO_W'(p1_n < 0 ? -p1_n : p1_n);
         p1_numer[i] = (rmq_pkg::NUMER_W'(p1_mag) << rmq_pkg::FRAC_BITS)
                       + rmq_pkg::NUMER_W'(p1_r);
         p1_side.sgn[i] = p1_n < 0;
         p1_side.ovf[i] = DW'(p1_numer[i]) >= (DW'(p1_d) << rmq_pkg::DIV_STEPS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= s1_valid[rmq_pkg::SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_numer_ff <= p1_numer;
         p1_d_ff     <= p1_d;
         p1_side_ff  <= p1_side;
      end
   end

   // ---------------- divider 1 chain ----------------
   logic                                               d1_valid [rmq_pkg::DIV_STEPS+1];
   logic [rmq_pkg::LANES-1:0][rmq_pkg::NUMER_W-1:0]    d1_rem   [rmq_pkg::DIV_STEPS+1];
   logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0]      d1_q     [rmq_pkg::DIV_STEPS+1];
   logic [rmq_pkg::DIV_D_W-1:0]                        d1_d     [rmq_pkg::DIV_STEPS+1];
   logic [DIV1_PW-1:0]                                 d1_side  [rmq_pkg::DIV_STEPS+1];

   assign d1_valid[0] = p1_valid_ff;
   assign d1_rem[0]   = p1_numer_ff;
   assign d1_q[0]     = '0;
   assign d1_d[0]     = p1_d_ff;
   assign d1_side[0]  = p1_side_ff;

   for (genvar g = 0; g < rmq_pkg::DIV_STEPS; g++) begin : g_dv1
      rmq_div_cell #(.J(rmq_pkg::DIV_STEPS-1-g), .PW(DIV1_PW)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(d1_valid[g]), .in_rem(d1_rem[g]), .in_q(d1_q[g]), .in_d(d1_d[g]),
         .in_side(d1_side[g]),
         .out_valid(d1_valid[g+1]), .out_rem(d1_rem[g+1]), .out_q(d1_q[g+1]),
         .out_d(d1_d[g+1]), .out_side(d1_side[g+1])
      );
   end

   // ---------------- components, sign and degenerate-axis fix ----------------
   rmq_pkg::div1_side_type                             c_in;
   logic [rmq_pkg::QUO_W-1:0]                          c_qv;
   logic [rmq_pkg::MAG_W-1:0]                          c_mag;
   logic                                               c_neg, c_zero;
   logic [rmq_pkg::BR_W-1:0]                           c_k;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::COMP_W-1:0]     c_val;
   logic                                               c_valid_ff;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::COMP_W-1:0]     c_val_ff;
   logic [rmq_pkg::BR_W-1:0]                           c_br_ff;

   always_comb begin
      c_in   = rmq_pkg::div1_side_type'(d1_side[rmq_pkg::DIV_STEPS]);
      c_k    = c_in.branch + rmq_pkg::BR_W'(1);
      c_zero = 1'b1;
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
         c_qv = d1_q[rmq_pkg::DIV_STEPS][i];
         if (rmq_pkg::BR_W'(i) == c_k) begin
            c_mag = (c_in.dom > rmq_pkg::ROOT_W'(rmq_pkg::ONE)) ? ONE_M
                    : rmq_pkg::MAG_W'(c_in.dom);
            c_neg = c_in.neg;
         end else if (c_in.r_zero) begin
            c_mag = '0;
            c_neg = 1'b0;
         end else begin
            c_mag = (c_in.ovf[i] || c_qv > ONE_Q) ? ONE_M : rmq_pkg::MAG_W'(c_qv);
            c_neg = c_in.sgn[i] ^ c_in.neg;
         end
         c_val[i] = c_neg ? -rmq_pkg::COMP_W'(c_mag) : rmq_pkg::COMP_W'(c_mag);
         if (rmq_pkg::BR_W'(i) != c_k && c_mag != '0) c_zero = 1'b0;
      end
      if (c_in.t_one && c_zero) c_val[c_k] = rmq_pkg::COMP_W'(rmq_pkg::ONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= d1_valid[rmq_pkg::DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_val_ff <= c_val;
         c_br_ff  <= c_in.branch;
      end
   end

   // ---------------- squares ----------------
   logic signed [31:0]                                 q_prod [rmq_pkg::LANES];
   logic                                               q_valid_ff;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::SQ_W-1:0]       q_sq_ff;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::COMP_W-1:0]     q_val_ff;
   logic [rmq_pkg::BR_W-1:0]                           q_br_ff;

   always_comb begin
      for (int i = 0; i < rmq_pkg::LANES; i++)
         q_prod[i] = $signed(c_val_ff[i]) * $signed(c_val_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else if (en) begin
         q_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < rmq_pkg::LANES; i++) q_sq_ff[i] <= rmq_pkg::SQ_W'(q_prod[i]);
         q_val_ff <= c_val_ff;
         q_br_ff  <= c_br_ff;
      end
   end

   // ---------------- squared length ----------------
   logic                                               l_valid_ff;
   logic [rmq_pkg::LEN2_W-1:0]                         l_len2_ff;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::COMP_W-1:0]     l_val_ff;
   logic [rmq_pkg::BR_W-1:0]                           l_br_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l_valid_ff <= 1'b0;
      end else if (en) begin
         l_valid_ff <= q_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l_len2_ff <= rmq_pkg::LEN2_W'(q_sq_ff[0]) + rmq_pkg::LEN2_W'(q_sq_ff[1])
                    + rmq_pkg::LEN2_W'(q_sq_ff[2]) + rmq_pkg::LEN2_W'(q_sq_ff[3]);
         l_val_ff  <= q_val_ff;
         l_br_ff   <= q_br_ff;
      end
   end

   // ---------------- deviation against threshold ----------------
   logic [rmq_pkg::LEN2_W-1:0]  v_dev;
   rmq_pkg::sq2_side_type       v_side;
   logic                        v_valid_ff;
   logic [rmq_pkg::RAD_W-1:0]   v_len2_ff;
   rmq_pkg::sq2_side_type       v_side_ff;

   always_comb begin
      v_dev = (l_len2_ff >= ONE_SQ) ? l_len2_ff - ONE_SQ : ONE_SQ - l_len2_ff;
      v_side.c      = l_val_ff;
      v_side.branch = l_br_ff;
      v_side.renorm = v_dev >= rmq_pkg::LEN2_W'(thr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff <= 1'b0;
      end else if (en) begin
         v_valid_ff <= l_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_len2_ff <= rmq_pkg::RAD_W'(l_len2_ff);
         v_side_ff <= v_side;
      end
   end

   // ---------------- root of the length ----------------
   logic                        s2_valid [rmq_pkg::SQRT_STEPS+1];
   logic [rmq_pkg::RAD_W-1:0]   s2_v     [rmq_pkg::SQRT_STEPS+1];
   logic [rmq_pkg::RAD_W-1:0]   s2_r     [rmq_pkg::SQRT_STEPS+1];
   logic [SQ2_PW-1:0]           s2_side  [rmq_pkg::SQRT_STEPS+1];

   assign s2_valid[0] = v_valid_ff;
   assign s2_v[0]     = v_len2_ff;
   assign s2_r[0]     = '0;
   assign s2_side[0]  = v_side_ff;

   for (genvar g = 0; g < rmq_pkg::SQRT_STEPS; g++) begin : g_sq2
      rmq_sqrt_cell #(.STEP(rmq_pkg::SQRT_STEPS-1-g), .PW(SQ2_PW)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(s2_valid[g]), .in_v(s2_v[g]), .in_r(s2_r[g]), .in_side(s2_side[g]),
         .out_valid(s2_valid[g+1]), .out_v(s2_v[g+1]), .out_r(s2_r[g+1]),
         .out_side(s2_side[g+1])
      );
   end

   // ---------------- divider 2 setup ----------------
   rmq_pkg::sq2_side_type                              p2_in;
   logic [rmq_pkg::ROOT_W-1:0]                         p2_len;
   logic [rmq_pkg::DIV_D_W-1:0]                        p2_d;
   logic signed [rmq_pkg::COMP_W-1:0]                  p2_c;
   logic [rmq_pkg::MAG_W-1:0]                          p2_mag;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::NUMER_W-1:0]    p2_numer;
   rmq_pkg::div2_side_type                             p2_side;
   logic                                               p2_valid_ff;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::NUMER_W-1:0]    p2_numer_ff;
   logic [rmq_pkg::DIV_D_W-1:0]                        p2_d_ff;
   rmq_pkg::div2_side_type                             p2_side_ff;

   always_comb begin
      p2_in  = rmq_pkg::sq2_side_type'(s2_side[rmq_pkg::SQRT_STEPS]);
      p2_len = s2_r[rmq_pkg::SQRT_STEPS][rmq_pkg::ROOT_W-1:0];
      p2_d   = rmq_pkg::DIV_D_W'(p2_len);
      p2_side.c        = p2_in.c;
      p2_side.branch   = p2_in.branch;
      p2_side.renorm   = p2_in.renorm;
      p2_side.len_zero = p2_len == '0;
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
         p2_c   = $signed(p2_in.c[i]);
         p2_mag = rmq_pkg::MAG_W'(p2_c < 0 ? -p2_c : p2_c);
         p2_numer[i] = (rmq_pkg::NUMER_W'(p2_mag) << rmq_pkg::FRAC_BITS)
                       + rmq_pkg::NUMER_W'(p2_len >> 1);
         p2_side.sgn[i] = p2_c < 0;
         p2_side.ovf[i] = DW'(p2_numer[i]) >= (DW'(p2_d) << rmq_pkg::DIV_STEPS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= s2_valid[rmq_pkg::SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_numer_ff <= p2_numer;
         p2_d_ff     <= p2_d;
         p2_side_ff  <= p2_side;
      end
   end

   // ---------------- divider 2 chain ----------------
   logic                                               d2_valid [rmq_pkg::DIV_STEPS+1];
   logic [rmq_pkg::LANES-1:0][rmq_pkg::NUMER_W-1:0]    d2_rem   [rmq_pkg::DIV_STEPS+1];
   logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0]      d2_q     [rmq_pkg::DIV_STEPS+1];
   logic [rmq_pkg::DIV_D_W-1:0]                        d2_d     [rmq_pkg::DIV_STEPS+1];
   logic [DIV2_PW-1:0]                                 d2_side  [rmq_pkg::DIV_STEPS+1];

   assign d2_valid[0] = p2_valid_ff;
   assign d2_rem[0]   = p2_numer_ff;
   assign d2_q[0]     = '0;
   assign d2_d[0]     = p2_d_ff;
   assign d2_side[0]  = p2_side_ff;

   for (genvar g = 0; g < rmq_pkg::DIV_STEPS; g++) begin : g_dv2
      rmq_div_cell #(.J(rmq_pkg::DIV_STEPS-1-g), .PW(DIV2_PW)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(d2_valid[g]), .in_rem(d2_rem[g]), .in_q(d2_q[g]), .in_d(d2_d[g]),
         .in_side(d2_side[g]),
         .out_valid(d2_valid[g+1]), .out_rem(d2_rem[g+1]), .out_q(d2_q[g+1]),
         .out_d(d2_d[g+1]), .out_side(d2_side[g+1])
      );
   end

   // ---------------- final selection and output register ----------------
   rmq_pkg::div2_side_type                             o_in;
   logic [rmq_pkg::QUO_W-1:0]                          o_qv;
   logic [rmq_pkg::MAG_W-1:0]                          o_mag;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::COMP_W-1:0]     o_val;
   logic                                               rsp_valid_ff;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::COMP_W-1:0]     rsp_val_ff;
   logic [rmq_pkg::BR_W-1:0]                           rsp_br_ff;
   logic                                               rsp_rn_ff;

   always_comb begin
      o_in = rmq_pkg::div2_side_type'(d2_side[rmq_pkg::DIV_STEPS]);
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
         o_qv  = d2_q[rmq_pkg::DIV_STEPS][i];
         o_mag = (o_in.ovf[i] || o_qv > ONE_Q) ? ONE_M : rmq_pkg::MAG_W'(o_qv);
         if (!o_in.renorm) begin
            o_val[i] = o_in.c[i];
         end else if (o_in.len_zero) begin
            o_val[i] = (i == rmq_pkg::LANE_X) ? rmq_pkg::COMP_W'(rmq_pkg::ONE) : '0;
         end else begin
            o_val[i] = o_in.sgn[i] ? -rmq_pkg::COMP_W'(o_mag) : rmq_pkg::COMP_W'(o_mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d2_valid[rmq_pkg::DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_val_ff <= o_val;
         rsp_br_ff  <= o_in.branch;
         rsp_rn_ff  <= o_in.renorm;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_quat_w           = $signed(rsp_val_ff[rmq_pkg::LANE_W]);
   assign rsp_quat_x           = $signed(rsp_val_ff[rmq_pkg::LANE_X]);
   assign rsp_quat_y           = $signed(rsp_val_ff[rmq_pkg::LANE_Y]);
   assign rsp_quat_z           = $signed(rsp_val_ff[rmq_pkg::LANE_Z]);
   assign rsp_branch_taken     = rsp_br_ff;
   assign rsp_was_renormalized = rsp_rn_ff;

   // ---------------- checks ----------------
   `RMQ_ASSERT_IMPLY(a_w_nonneg, clock, reset, rsp_valid, !rsp_quat_w[rmq_pkg::COMP_W-1])
   `RMQ_ASSERT_IMPLY(a_hold_in, clock, reset, rsp_valid && rsp_stall, req_stall)
   `RMQ_ASSERT_NEXT(a_out_load, clock, reset, d2_valid[rmq_pkg::DIV_STEPS] && en, rsp_valid)
   `RMQ_ASSERT_IMPLY(a_x_range, clock, reset, rsp_valid, rsp_quat_x <= ONE_C && rsp_quat_x >= -ONE_C)

endmodule

`default_nettype wire
